@@ rtl/qsd_pkg.sv @@
package qsd_pkg;

    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    localparam logic [1:0] PCT_NONE = 2'd0;
    localparam logic [1:0] PCT_ONE  = 2'd1;
    localparam logic [1:0] PCT_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_valid;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       in_value;
        logic       param_end;
        logic       query_done;
        logic [1:0] status;
    } out_word_t;

    typedef struct packed {
        logic       at_start;
        logic       value_part;
        logic       token_seen;
        logic [1:0] pct_phase;
        logic [7:0] pending_char;
        logic       error_hold;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        at_start:     1'b1,
        value_part:   1'b0,
        token_seen:   1'b0,
        pct_phase:    PCT_NONE,
        pending_char: 8'h00,
        error_hold:   1'b0
    };

endpackage

@@ rtl/qsd_step.sv @@
module qsd_step (
    input  qsd_pkg::parse_state_t st,
    input  qsd_pkg::in_word_t     word,
    output qsd_pkg::parse_state_t st_next,
    output qsd_pkg::out_word_t    res,
    output logic                  has_result
);
    import qsd_pkg::*;

    // {hex digit, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

    logic [7:0] c;
    logic       term;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [1:0] status;

    assign c    = word.in_byte;
    assign term = (c == CH_AMP) || (c == CH_EQUAL && !st.value_part);
    assign hi   = hex_nibble(st.pending_char);
    assign lo   = hex_nibble(c);

    always_comb
    begin
        st_next = st;
        res     = '0;
        status  = ST_OK;
        if (st.error_hold)
        begin
            if (word.last)
            begin
                st_next = STATE_RESET;
            end
        end
        else if (word.byte_valid || word.last)
        begin
            if (word.byte_valid)
            begin
                if (st.at_start && c == CH_QUESTION)
                begin
                    st_next.at_start = 1'b0;
                end
                else
                begin
                    st_next.at_start = 1'b0;
                    if (st.pct_phase != PCT_NONE && term)
                    begin
                        status = ST_TRUNCATED;
                    end
                    else if (st.pct_phase == PCT_ONE)
                    begin
                        st_next.pending_char = c;
                        st_next.pct_phase    = PCT_TWO;
                    end
                    else if (st.pct_phase == PCT_TWO)
                    begin
                        if (!hi[4] || !lo[4])
                        begin
                            status = ST_INVALID;
                        end
                        else
                        begin
                            res.out_byte         = {hi[3:0], lo[3:0]};
                            res.byte_present     = 1'b1;
                            res.in_value         = st.value_part;
                            st_next.pct_phase    = PCT_NONE;
                            st_next.pending_char = 8'h00;
                        end
                    end
                    else if (c == CH_AMP)
                    begin
                        res.param_end      = st.token_seen;
                        st_next.token_seen = 1'b0;
                        st_next.value_part = 1'b0;
                    end
                    else if (c == CH_EQUAL)
                    begin
                        st_next.value_part = 1'b1;
                        st_next.token_seen = 1'b1;
                    end
                    else if (c == CH_PERCENT)
                    begin
                        st_next.pct_phase  = PCT_ONE;
                        st_next.token_seen = 1'b1;
                    end
                    else
                    begin
                        res.out_byte       = (c == CH_PLUS) ? CH_SPACE : c;
                        res.byte_present   = 1'b1;
                        res.in_value       = st.value_part;
                        st_next.token_seen = 1'b1;
                    end
                end
            end
            if (status == ST_OK && word.last)
            begin
                if (st_next.pct_phase != PCT_NONE)
                begin
                    status = ST_TRUNCATED;
                end
                else
                begin
                    if (st_next.token_seen)
                    begin
                        res.param_end = 1'b1;
                    end
                    res.query_done = 1'b1;
                end
            end
            if (status != ST_OK)
            begin
                res        = '0;
                res.status = status;
                if (word.last)
                begin
                    st_next = STATE_RESET;
                end
                else
                begin
                    st_next.error_hold = 1'b1;
                end
            end
            else if (word.last)
            begin
                st_next = STATE_RESET;
            end
        end
    end

    assign has_result = res.byte_present || res.param_end || res.query_done
                        || (res.status != ST_OK);

endmodule

@@ rtl/qsd_out_reg.sv @@
module qsd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  qsd_pkg::out_word_t load_word,
    output logic               free,
    output logic               result_valid,
    input  logic               result_stall,
    output qsd_pkg::out_word_t result_word
);
    import qsd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign free       = !valid_reg || !result_stall;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

endmodule

@@ rtl/query_string_decoder.sv @@
// channel   | handshake                    | word
// query     | query_valid / query_stall    | query_word  (in_word_t)
// result    | result_valid / result_stall  | result_word (out_word_t)
//
// one byte a cycle while query_stall is low; a taken byte goes from the input register to the result register
// bytes that give no result leave the input register without waiting for the output
// reset clears the parse state and both valid flags
// query_stall rises only when the input register holds a byte with a result
// and the result register is full and stalled
module query_string_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  qsd_pkg::in_word_t  query_word,
    output logic               result_valid,
    input  logic               result_stall,
    output qsd_pkg::out_word_t result_word
);
    import qsd_pkg::*;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    in_word_t     s1_word_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    out_word_t    step_res;
    logic         step_has;
    logic         out_free;
    logic         s1_go;

    qsd_step u_step (
        .st         (state_reg),
        .word       (s1_word_reg),
        .st_next    (state_next),
        .res        (step_res),
        .has_result (step_has)
    );

    assign s1_go         = s1_valid_reg && (!step_has || out_free);
    assign query_stall   = s1_valid_reg && !s1_go;
    assign s1_valid_next = query_stall ? s1_valid_reg : query_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_go)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_valid && !query_stall)
        begin
            s1_word_reg <= query_word;
        end
    end

    qsd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_go && step_has),
        .load_word    (step_res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

@@ tb/query_string_decoder_test.sv @@
`timescale 1ns / 1ps

module query_string_decoder_test;

    import qsd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 250;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      query_valid  = 1'b0;
    logic      query_stall;
    in_word_t  query_word   = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result_word;

    query_string_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query_word   (query_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    parse_state_t parser_state = STATE_RESET;
    out_word_t    pending_results[$];
    out_word_t    got_word;
    out_word_t    want_word;

    bit gaps_on      = 1'b1;
    int hold_len     = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    int errors       = 0;
    int bytes_sent   = 0;
    int words_seen   = 0;
    int queries      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41 + 8'd10);
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input int d, input bit upper);
        if (d < 10)
            return 8'(8'h30 + d);
        return 8'((upper ? 8'h41 : 8'h61) + d - 10);
    endfunction

    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    // advances the parse state by one query word
    function automatic bit decode_query_byte(input in_word_t w, output out_word_t r);
        bit         term;
        int         hi;
        int         lo;
        logic [1:0] st;
        r  = '0;
        st = ST_OK;
        if (parser_state.error_hold)
        begin
            if (w.last)
                parser_state = STATE_RESET;
            return 1'b0;
        end
        if (!w.byte_valid && !w.last)
            return 1'b0;
        if (w.byte_valid)
        begin
            if (parser_state.at_start && w.in_byte == CH_QUESTION)
            begin
                parser_state.at_start = 1'b0;
            end
            else
            begin
                term = (w.in_byte == CH_AMP) ||
                       (w.in_byte == CH_EQUAL && !parser_state.value_part);
                parser_state.at_start = 1'b0;
                if (parser_state.pct_phase != PCT_NONE && term)
                begin
                    st = ST_TRUNCATED;
                end
                else if (parser_state.pct_phase == PCT_ONE)
                begin
                    parser_state.pending_char = w.in_byte;
                    parser_state.pct_phase    = PCT_TWO;
                end
                else if (parser_state.pct_phase == PCT_TWO)
                begin
                    hi = hex_nibble(parser_state.pending_char);
                    lo = hex_nibble(w.in_byte);
                    if (hi < 0 || lo < 0)
                    begin
                        st = ST_INVALID;
                    end
                    else
                    begin
                        r.out_byte                = {hi[3:0], lo[3:0]};
                        r.byte_present            = 1'b1;
                        r.in_value                = parser_state.value_part;
                        parser_state.pct_phase    = PCT_NONE;
                        parser_state.pending_char = 8'h00;
                    end
                end
                else if (w.in_byte == CH_AMP)
                begin
                    r.param_end             = parser_state.token_seen;
                    parser_state.token_seen = 1'b0;
                    parser_state.value_part = 1'b0;
                end
                else if (w.in_byte == CH_EQUAL)
                begin
                    parser_state.value_part = 1'b1;
                    parser_state.token_seen = 1'b1;
                end
                else if (w.in_byte == CH_PERCENT)
                begin
                    parser_state.pct_phase  = PCT_ONE;
                    parser_state.token_seen = 1'b1;
                end
                else
                begin
                    r.out_byte              = (w.in_byte == CH_PLUS) ? CH_SPACE : w.in_byte;
                    r.byte_present          = 1'b1;
                    r.in_value              = parser_state.value_part;
                    parser_state.token_seen = 1'b1;
                end
            end
        end
        if (st == ST_OK && w.last)
        begin
            if (parser_state.pct_phase != PCT_NONE)
            begin
                st = ST_TRUNCATED;
            end
            else
            begin
                if (parser_state.token_seen)
                    r.param_end = 1'b1;
                r.query_done = 1'b1;
            end
        end
        if (st != ST_OK)
        begin
            r        = '0;
            r.status = st;
            if (w.last)
                parser_state = STATE_RESET;
            else
                parser_state.error_hold = 1'b1;
        end
        else if (w.last)
        begin
            parser_state = STATE_RESET;
        end
        return r.byte_present || r.param_end || r.query_done || r.status != ST_OK;
    endfunction

    task automatic send_word(input logic [7:0] b, input bit valid, input bit fin);
        in_word_t  w;
        out_word_t r;
        int        gap;
        w.in_byte    = b;
        w.byte_valid = valid;
        w.last       = fin;
        gap = gaps_on ? random_gap() : 0;
        if (gap != 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        query_word  <= w;
        do
            @(posedge clk);
        while (query_stall);
        bytes_sent++;
        if (decode_query_byte(w, r))
            pending_results.insert(pending_results.size(), r);
    endtask

    task automatic send_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, fin && i == s.len() - 1);
    endtask

    task automatic drain_results();
        query_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic void append_text(ref logic [7:0] q[$], input bit value_side,
                                        input int len);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 3)
            begin
                add_byte(q, CH_PERCENT);
                add_byte(q, hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
                add_byte(q, hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            end
            else if (pick == 3)
                add_byte(q, CH_PLUS);
            else if (pick == 4)
                add_byte(q, value_side ? CH_EQUAL : CH_QUESTION);
            else if (pick == 5)
                add_byte(q, 8'(8'h80 + $urandom_range(0, 127)));
            else if (pick == 6)
                add_byte(q, 8'(8'h30 + $urandom_range(0, 9)));
            else
                add_byte(q, 8'(8'h61 + $urandom_range(0, 25)));
        end
    endfunction

    task automatic send_random_query();
        logic [7:0] text[$];
        int         kind;
        int         n;
        int         spot;
        bit         empty_end;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                add_byte(text, 8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                add_byte(text, CH_QUESTION);
            n = $urandom_range(1, 4);
            for (int p = 0; p < n; p++)
            begin
                if (p != 0)
                begin
                    add_byte(text, CH_AMP);
                    if ($urandom_range(0, 5) == 0)
                        add_byte(text, CH_AMP);
                end
                append_text(text, 1'b0, $urandom_range(0, 5));
                if ($urandom_range(0, 4) != 0)
                begin
                    add_byte(text, CH_EQUAL);
                    append_text(text, 1'b1, $urandom_range(0, 6));
                end
            end
            // broken percent sequences
            if (kind == 1)
            begin
                spot = $urandom_range(0, text.size());
                text.insert(spot, CH_PERCENT);
                text.insert(spot + 1, 8'($urandom_range(0, 255)));
            end
            else if (kind == 2)
            begin
                add_byte(text, CH_PERCENT);
            end
        end
        empty_end = (text.size() == 0) || ($urandom_range(0, 7) == 0);
        for (int i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(text[i], 1'b1, !empty_end && i == text.size() - 1);
        end
        if (empty_end)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        queries++;
    endtask

    task automatic test_directed();
        send_text("??=+%4a&&=%=F", 1'b1);
        send_text("%ff%00", 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_text("%g&", 1'b0);
        send_word(8'h5A, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_text("=x", 1'b1);
        queries += 6;
        drain_results();
    endtask

    task automatic test_back_pressure();
        gaps_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_word(8'(8'h61 + i % 26), 1'b1, i == 39);
        gaps_on = 1'b1;
        queries++;
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_text("a=1&b", 1'b0);
        drain_results();
        send_text("=2&c+d", 1'b1);
        queries++;
        drain_results();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int i = 0; i < 20; i++)
            send_random_query();
        gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_queries();
        while (bytes_sent < RANDOM_ITEMS)
        begin
            send_random_query();
            if ($urandom_range(0, 29) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // result side stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                result_stall <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            else
            begin
                stall_left = gaps_on ? random_gap() : 0;
                result_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_word = result_word;
            words_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word %h with nothing pending", got_word);
                errors++;
            end
            else
            begin
                want_word = pending_results.pop_front();
                if (got_word.out_byte !== want_word.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h",
                           want_word.out_byte, got_word.out_byte);
                    errors++;
                end
                if (got_word.byte_present !== want_word.byte_present)
                begin
                    $error("byte_present: expected %0b, got %0b",
                           want_word.byte_present, got_word.byte_present);
                    errors++;
                end
                if (got_word.in_value !== want_word.in_value)
                begin
                    $error("in_value: expected %0b, got %0b",
                           want_word.in_value, got_word.in_value);
                    errors++;
                end
                if (got_word.param_end !== want_word.param_end)
                begin
                    $error("param_end: expected %0b, got %0b",
                           want_word.param_end, got_word.param_end);
                    errors++;
                end
                if (got_word.query_done !== want_word.query_done)
                begin
                    $error("query_done: expected %0b, got %0b",
                           want_word.query_done, got_word.query_done);
                    errors++;
                end
                if (got_word.status !== want_word.status)
                begin
                    $error("status: expected %0d, got %0d",
                           want_word.status, got_word.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((query_valid && !query_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_pressure();
        test_sender_pause();
        test_back_to_back();
        test_random_queries();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            errors++;
        end
        $display("%0d queries, %0d bytes offered, %0d result words checked",
                 queries, bytes_sent, words_seen);
        $display("covered percent decoding, errors, empty parameters and back-pressure");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ query_string_decoder.f @@
rtl/qsd_pkg.sv
rtl/qsd_step.sv
rtl/qsd_out_reg.sv
rtl/query_string_decoder.sv
tb/query_string_decoder_test.sv
